// ===== rtl/pdg_pkg.sv =====
// Shared types and constants of the pass dependency grouper.
package pdg_pkg;

    // Default sizes of the block
    localparam int DEF_RESOURCES         = 256;
    localparam int DEF_MAX_PASS_ACCESSES = 32;
    localparam int DEF_MAX_GROUPS        = 256;

    // Fixed widths of the transaction fields
    localparam int RESOURCE_W    = 8;
    localparam int GROUP_OUT_W   = 8;
    localparam int COUNT_OUT_W   = 9;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_WB_RD,
        ST_WB_WR,
        ST_EMIT
    } state_t;

    // Control of the dependency tables
    typedef struct packed {
        logic lookup;
        logic rd_we;
        logic wr_we;
    } tbl_cmd_t;

endpackage

// ===== rtl/pdg_dep_table.sv =====
// Per-resource last read group and last write group memories.
module pdg_dep_table #(
    parameter int RESOURCES = pdg_pkg::DEF_RESOURCES,
    parameter int TBL_W     = 9,
    parameter int RES_W     = 8
) (
    input  logic                 aclk,
    input  pdg_pkg::tbl_cmd_t    cmd,
    input  logic [RES_W-1:0]     rd_addr,
    input  logic [RES_W-1:0]     wr_addr,
    input  logic [TBL_W-1:0]     wr_data,
    output logic [TBL_W-1:0]     last_read,
    output logic [TBL_W-1:0]     last_write
);

    logic [TBL_W-1:0] read_mem  [RESOURCES];
    logic [TBL_W-1:0] write_mem [RESOURCES];
    logic [TBL_W-1:0] last_read_reg;
    logic [TBL_W-1:0] last_write_reg;

    // Update entries on the shared write port
    always_ff @(posedge aclk) begin
        if (cmd.rd_we) begin
            read_mem[wr_addr] <= wr_data;
        end
        if (cmd.wr_we) begin
            write_mem[wr_addr] <= wr_data;
        end
    end

    // Register both entries of one resource for a lookup
    always_ff @(posedge aclk) begin
        if (cmd.lookup) begin
            last_read_reg  <= read_mem[rd_addr];
            last_write_reg <= write_mem[rd_addr];
        end
    end

    assign last_read  = last_read_reg;
    assign last_write = last_write_reg;

endmodule

// ===== rtl/pdg_pass_buf.sv =====
// Buffer of the accesses of the pass in progress.
module pdg_pass_buf #(
    parameter int DEPTH = pdg_pkg::DEF_MAX_PASS_ACCESSES,
    parameter int ENT_W = 10,
    parameter int IDX_W = 5
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [IDX_W-1:0] waddr,
    input  logic [ENT_W-1:0] wdata,
    input  logic             re,
    input  logic [IDX_W-1:0] raddr,
    output logic [ENT_W-1:0] rdata
);

    logic [ENT_W-1:0] buf_mem [DEPTH];
    logic [ENT_W-1:0] rdata_reg;

    // Store one access
    always_ff @(posedge aclk) begin
        if (we) begin
            buf_mem[waddr] <= wdata;
        end
    end

    // Read one access for write-back
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= buf_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/pass_dependency_grouper_top.sv =====
// Top level of the pass dependency grouper: sequencer, lookup unit and output register.
// Each access transaction with s_access_present and a resource below RESOURCES is
// accepted while both dependency tables are read at that resource; its group is then
// folded into the pass. A transaction with pass_end then writes the pass group back
// for each buffered access, reading it from the pass buffer and then writing through
// the single table write port, and finally loads the result register once the
// previous result has been taken. Reset and every new-frame transaction start a
// clearing sweep over all RESOURCES entries (256 by default) of both tables, during which
// no transaction is accepted; the configuration register can be written at any time.
module pass_dependency_grouper_top #(
    parameter int RESOURCES         = pdg_pkg::DEF_RESOURCES,
    parameter int MAX_PASS_ACCESSES = pdg_pkg::DEF_MAX_PASS_ACCESSES,
    parameter int MAX_GROUPS        = pdg_pkg::DEF_MAX_GROUPS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration
    input  logic                              cfg_wr_en,
    input  logic                              cfg_wr_data,
    // Access channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_mode,
    input  logic [pdg_pkg::RESOURCE_W-1:0]    s_resource,
    input  logic                              s_access_present,
    input  logic                              s_first_access,
    input  logic                              s_reads,
    input  logic                              s_writes,
    input  logic                              s_layout_changes,
    input  logic                              s_pass_end,
    // Result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [pdg_pkg::GROUP_OUT_W-1:0]   m_group,
    output logic [pdg_pkg::COUNT_OUT_W-1:0]   m_group_count,
    output logic                              m_bad_access,
    output logic                              m_overflow
);

    localparam int RES_W = $clog2(RESOURCES);
    localparam int GRP_W = $clog2(MAX_GROUPS);
    localparam int TBL_W = GRP_W + 1;
    localparam int CNT_W = $clog2(MAX_PASS_ACCESSES + 1);
    localparam int IDX_W = (MAX_PASS_ACCESSES > 1) ? $clog2(MAX_PASS_ACCESSES) : 1;
    localparam int ENT_W = RES_W + 2;

    localparam logic [TBL_W-1:0] GRP_NONE = '1;
    localparam logic [TBL_W-1:0] GRP_TOP  = TBL_W'(MAX_GROUPS - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_PASS_ACCESSES);
    localparam logic [RES_W-1:0] CLR_LAST = RES_W'(RESOURCES - 1);

    pdg_pkg::state_t state_reg, state_next;

    logic             serialize_reg;
    logic [RES_W-1:0] clr_addr_reg, clr_addr_next;
    logic [RES_W-1:0] addr_reg, addr_next;
    logic             first_reg, first_next;
    logic             rd_reg, rd_next;
    logic             wr_reg, wr_next;
    logic             lay_reg, lay_next;
    logic             end_reg, end_next;
    logic [GRP_W-1:0] earliest_reg, earliest_next;
    logic [GRP_W-1:0] highest_reg, highest_next;
    logic             bad_reg, bad_next;
    logic             ovf_reg, ovf_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] wb_idx_reg, wb_idx_next;

    logic                            m_valid_reg, m_valid_next;
    logic [pdg_pkg::GROUP_OUT_W-1:0] m_group_reg, m_group_next;
    logic [pdg_pkg::COUNT_OUT_W-1:0] m_count_reg, m_count_next;
    logic                            m_bad_reg, m_bad_next;
    logic                            m_ovf_reg, m_ovf_next;

    logic [31:0]      res_ext;
    logic             in_range;
    logic [RES_W-1:0] s_addr;
    logic             in_fire;
    logic             out_free;
    logic             emit;
    logic             buf_full;
    logic             wb_done;

    pdg_pkg::tbl_cmd_t tbl_cmd;
    logic [RES_W-1:0]  tbl_waddr;
    logic [TBL_W-1:0]  tbl_wdata;
    logic [TBL_W-1:0]  tbl_last_read;
    logic [TBL_W-1:0]  tbl_last_write;

    logic             buf_we;
    logic             buf_re;
    logic [ENT_W-1:0] buf_wdata;
    logic [ENT_W-1:0] buf_rdata;
    logic [RES_W-1:0] ent_addr;
    logic             ent_rd;
    logic             ent_wr;

    logic [TBL_W-1:0] after_rd;
    logic [TBL_W-1:0] after_wr;
    logic [TBL_W-1:0] after_both;
    logic [TBL_W-1:0] need;
    logic             bad_now;
    logic             clamp;
    logic [GRP_W-1:0] acc_grp;
    logic [GRP_W-1:0] hi_new;
    logic [31:0]      grp_ext;
    logic [31:0]      cnt_ext;

    // Decode the incoming resource index
    assign res_ext  = 32'(s_resource);
    assign in_range = res_ext < 32'(RESOURCES);
    assign s_addr   = res_ext[RES_W-1:0];
    assign in_fire  = s_valid & s_ready;
    assign out_free = ~m_valid_reg | m_ready;
    assign buf_full = count_reg >= CNT_FULL;
    assign wb_done  = wb_idx_reg == count_reg;

    assign {ent_addr, ent_rd, ent_wr} = buf_rdata;
    assign buf_wdata = {addr_reg, rd_reg, wr_reg};

    // Group that one access asks for, from the looked-up table entries
    always_comb begin
        after_rd   = (tbl_last_read == GRP_NONE) ? '0 : tbl_last_read + TBL_W'(1);
        after_wr   = (tbl_last_write == GRP_NONE) ? '0 : tbl_last_write + TBL_W'(1);
        after_both = (after_rd > after_wr) ? after_rd : after_wr;
        bad_now    = 1'b0;
        if (first_reg) begin
            need = '0;
        end else if (wr_reg || serialize_reg) begin
            need = after_both;
        end else if (rd_reg) begin
            need = lay_reg ? after_both : after_wr;
        end else begin
            need    = '0;
            bad_now = 1'b1;
        end
        clamp   = need > GRP_TOP;
        acc_grp = clamp ? GRP_TOP[GRP_W-1:0] : need[GRP_W-1:0];
    end

    // Result fields of the finished pass
    assign hi_new  = (earliest_reg > highest_reg) ? earliest_reg : highest_reg;
    assign grp_ext = 32'(earliest_reg);
    assign cnt_ext = 32'(hi_new) + 32'd1;

    // Advance the sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pdg_pkg::ST_CLEAR: begin
                if (clr_addr_reg == CLR_LAST) begin
                    state_next = pdg_pkg::ST_IDLE;
                end
            end
            pdg_pkg::ST_IDLE: begin
                if (in_fire) begin
                    if (s_mode) begin
                        state_next = pdg_pkg::ST_CLEAR;
                    end else if (s_access_present && in_range) begin
                        state_next = pdg_pkg::ST_LOOK;
                    end else if (s_pass_end) begin
                        state_next = pdg_pkg::ST_WB_RD;
                    end
                end
            end
            pdg_pkg::ST_LOOK: begin
                state_next = end_reg ? pdg_pkg::ST_WB_RD : pdg_pkg::ST_IDLE;
            end
            pdg_pkg::ST_WB_RD: begin
                state_next = wb_done ? pdg_pkg::ST_EMIT : pdg_pkg::ST_WB_WR;
            end
            pdg_pkg::ST_WB_WR: begin
                state_next = pdg_pkg::ST_WB_RD;
            end
            pdg_pkg::ST_EMIT: begin
                if (out_free) begin
                    state_next = pdg_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pdg_pkg::ST_CLEAR;
            end
        endcase
    end

    // Drive the memories and the handshake from the state
    always_comb begin
        s_ready        = 1'b0;
        tbl_cmd.lookup = 1'b0;
        tbl_cmd.rd_we  = 1'b0;
        tbl_cmd.wr_we  = 1'b0;
        tbl_waddr      = ent_addr;
        tbl_wdata      = {1'b0, earliest_reg};
        buf_we         = 1'b0;
        buf_re         = 1'b0;
        emit           = 1'b0;
        case (state_reg)
            pdg_pkg::ST_CLEAR: begin
                tbl_cmd.rd_we = 1'b1;
                tbl_cmd.wr_we = 1'b1;
                tbl_waddr     = clr_addr_reg;
                tbl_wdata     = GRP_NONE;
            end
            pdg_pkg::ST_IDLE: begin
                s_ready        = 1'b1;
                tbl_cmd.lookup = s_valid;
            end
            pdg_pkg::ST_LOOK: begin
                buf_we = ~buf_full;
            end
            pdg_pkg::ST_WB_RD: begin
                buf_re = ~wb_done;
            end
            pdg_pkg::ST_WB_WR: begin
                tbl_cmd.rd_we = ent_rd;
                tbl_cmd.wr_we = ent_wr;
            end
            pdg_pkg::ST_EMIT: begin
                emit = out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // Compute the next datapath values
    always_comb begin
        clr_addr_next = clr_addr_reg;
        addr_next     = addr_reg;
        first_next    = first_reg;
        rd_next       = rd_reg;
        wr_next       = wr_reg;
        lay_next      = lay_reg;
        end_next      = end_reg;
        earliest_next = earliest_reg;
        highest_next  = highest_reg;
        bad_next      = bad_reg;
        ovf_next      = ovf_reg;
        count_next    = count_reg;
        wb_idx_next   = wb_idx_reg;
        m_group_next  = m_group_reg;
        m_count_next  = m_count_reg;
        m_bad_next    = m_bad_reg;
        m_ovf_next    = m_ovf_reg;
        m_valid_next  = m_valid_reg & ~m_ready;

        // Sweep the tables
        if (state_reg == pdg_pkg::ST_CLEAR) begin
            clr_addr_next = (clr_addr_reg == CLR_LAST) ? '0 : clr_addr_reg + RES_W'(1);
        end

        // Capture the accepted transaction; drop the frame on a new-frame one
        if (in_fire) begin
            addr_next   = s_addr;
            first_next  = s_first_access;
            rd_next     = s_reads;
            wr_next     = s_writes;
            lay_next    = s_layout_changes;
            end_next    = s_pass_end;
            wb_idx_next = '0;
            if (s_mode) begin
                clr_addr_next = '0;
                earliest_next = '0;
                highest_next  = '0;
                bad_next      = 1'b0;
                ovf_next      = 1'b0;
                count_next    = '0;
            end
        end

        // Fold one access into the pass
        if (state_reg == pdg_pkg::ST_LOOK) begin
            if (acc_grp > earliest_reg) begin
                earliest_next = acc_grp;
            end
            bad_next = bad_reg | bad_now;
            ovf_next = ovf_reg | clamp | buf_full;
            if (!buf_full) begin
                count_next = count_reg + CNT_W'(1);
            end
        end

        // Step through the buffered accesses
        if (state_reg == pdg_pkg::ST_WB_WR) begin
            wb_idx_next = wb_idx_reg + CNT_W'(1);
        end

        // Hand the result over and start a new pass
        if (emit) begin
            m_valid_next  = 1'b1;
            m_group_next  = grp_ext[pdg_pkg::GROUP_OUT_W-1:0];
            m_count_next  = cnt_ext[pdg_pkg::COUNT_OUT_W-1:0];
            m_bad_next    = bad_reg;
            m_ovf_next    = ovf_reg;
            highest_next  = hi_new;
            earliest_next = '0;
            bad_next      = 1'b0;
            ovf_next      = 1'b0;
            count_next    = '0;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= pdg_pkg::ST_CLEAR;
            serialize_reg <= 1'b0;
            clr_addr_reg  <= '0;
            earliest_reg  <= '0;
            highest_reg   <= '0;
            bad_reg       <= 1'b0;
            ovf_reg       <= 1'b0;
            count_reg     <= '0;
            wb_idx_reg    <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            serialize_reg <= cfg_wr_en ? cfg_wr_data : serialize_reg;
            clr_addr_reg  <= clr_addr_next;
            earliest_reg  <= earliest_next;
            highest_reg   <= highest_next;
            bad_reg       <= bad_next;
            ovf_reg       <= ovf_next;
            count_reg     <= count_next;
            wb_idx_reg    <= wb_idx_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        addr_reg    <= addr_next;
        first_reg   <= first_next;
        rd_reg      <= rd_next;
        wr_reg      <= wr_next;
        lay_reg     <= lay_next;
        end_reg     <= end_next;
        m_group_reg <= m_group_next;
        m_count_reg <= m_count_next;
        m_bad_reg   <= m_bad_next;
        m_ovf_reg   <= m_ovf_next;
    end

    pdg_dep_table #(
        .RESOURCES (RESOURCES),
        .TBL_W     (TBL_W),
        .RES_W     (RES_W)
    ) u_dep_table (
        .aclk       (aclk),
        .cmd        (tbl_cmd),
        .rd_addr    (s_addr),
        .wr_addr    (tbl_waddr),
        .wr_data    (tbl_wdata),
        .last_read  (tbl_last_read),
        .last_write (tbl_last_write)
    );

    pdg_pass_buf #(
        .DEPTH (MAX_PASS_ACCESSES),
        .ENT_W (ENT_W),
        .IDX_W (IDX_W)
    ) u_pass_buf (
        .aclk  (aclk),
        .we    (buf_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (buf_wdata),
        .re    (buf_re),
        .raddr (wb_idx_reg[IDX_W-1:0]),
        .rdata (buf_rdata)
    );

    assign m_valid       = m_valid_reg;
    assign m_group       = m_group_reg;
    assign m_group_count = m_count_reg;
    assign m_bad_access  = m_bad_reg;
    assign m_overflow    = m_ovf_reg;

`ifndef SYNTHESIS
    // Buffer fill never passes its depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_FULL)
        else $error("pass buffer count beyond depth");

    // Write-back only touches buffered entries
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == pdg_pkg::ST_WB_WR |-> wb_idx_reg < count_reg)
        else $error("write-back index beyond buffered count");

    // A new result comes only from the emit step
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == pdg_pkg::ST_EMIT)
        else $error("result raised outside emit");

    // Emitting a pass leaves an empty pass behind
    assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> count_reg == '0 && earliest_reg == '0 && !bad_reg && !ovf_reg)
        else $error("pass state not cleared after emit");
`endif

endmodule

// ===== tb/pass_dependency_grouper_top_tb.sv =====
// Self-checking testbench of the pass dependency grouper top level.
`timescale 1ns / 100ps

module pass_dependency_grouper_top_tb;

    localparam int RES_N          = pdg_pkg::DEF_RESOURCES;
    localparam int BUF_N          = pdg_pkg::DEF_MAX_PASS_ACCESSES;
    localparam int GROUP_N        = pdg_pkg::DEF_MAX_GROUPS;
    localparam int SETTLE_CYCLES  = 320;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT    = 600000;
    localparam logic [8:0] NO_GROUP = 9'h1FF;

    // One access transaction as driven on the s_ ports
    typedef struct packed {
        logic                           mode;
        logic [pdg_pkg::RESOURCE_W-1:0] res;
        logic                           present;
        logic                           first;
        logic                           rd;
        logic                           wr;
        logic                           lay;
        logic                           pend;
    } access_t;

    // One finished pass as seen on the m_ ports
    typedef struct packed {
        logic [pdg_pkg::GROUP_OUT_W-1:0] grp;
        logic [pdg_pkg::COUNT_OUT_W-1:0] count;
        logic                            bad;
        logic                            ovf;
    } pass_result_t;

    typedef struct packed {
        logic [pdg_pkg::RESOURCE_W-1:0] res;
        logic                           rd;
        logic                           wr;
    } logged_access_t;

    logic                            aclk;
    logic                            aresetn;
    logic                            cfg_wr_en;
    logic                            cfg_wr_data;
    logic                            s_valid;
    logic                            s_ready;
    logic                            s_mode;
    logic [pdg_pkg::RESOURCE_W-1:0]  s_resource;
    logic                            s_access_present;
    logic                            s_first_access;
    logic                            s_reads;
    logic                            s_writes;
    logic                            s_layout_changes;
    logic                            s_pass_end;
    logic                            m_valid;
    logic                            m_ready;
    logic [pdg_pkg::GROUP_OUT_W-1:0] m_group;
    logic [pdg_pkg::COUNT_OUT_W-1:0] m_group_count;
    logic                            m_bad_access;
    logic                            m_overflow;

    // Group tracking state of the predictor
    logic [8:0]             last_rd_grp [RES_N];
    logic [8:0]             last_wr_grp [RES_N];
    logged_access_t         pass_log[$];
    logic [7:0]             pass_floor;
    logic [7:0]             frame_top;
    logic                   flag_bad;
    logic                   flag_ovf;
    logic                   serialize_mdl;
    pass_result_t           expected_passes[$];

    bit                     idle_on;
    bit                     rx_hold_req;
    int                     fail_count;
    int                     items_sent;
    int                     results_checked;
    int                     frames_seen;
    int                     ovf_results;
    int                     bad_results;
    int unsigned            cycle_count;

    pass_dependency_grouper_top i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_mode           (s_mode),
        .s_resource       (s_resource),
        .s_access_present (s_access_present),
        .s_first_access   (s_first_access),
        .s_reads          (s_reads),
        .s_writes         (s_writes),
        .s_layout_changes (s_layout_changes),
        .s_pass_end       (s_pass_end),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_group          (m_group),
        .m_group_count    (m_group_count),
        .m_bad_access     (m_bad_access),
        .m_overflow       (m_overflow)
    );

    always #1 aclk = ~aclk;

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $error("timeout after %0d cycles, %0d passes outstanding", cycle_count,
                   expected_passes.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------- predictor

    function automatic void clear_frame_mdl();
        foreach (last_rd_grp[i]) begin
            last_rd_grp[i] = NO_GROUP;
            last_wr_grp[i] = NO_GROUP;
        end
        pass_log.delete();
        pass_floor = '0;
        frame_top  = '0;
        flag_bad   = 1'b0;
        flag_ovf   = 1'b0;
    endfunction

    // Fold one accepted transaction into the frame state; queue the pass group at pass end
    function automatic void assign_pass_group(input access_t a);
        logic [8:0]     after_rd;
        logic [8:0]     after_wr;
        logic [8:0]     both;
        int             g;
        logged_access_t e;
        pass_result_t   r;
        if (a.mode) begin
            clear_frame_mdl();
            frames_seen++;
            return;
        end
        // Resource index always fits the table at the default size
        if (a.present) begin
            after_rd = last_rd_grp[a.res] + 9'd1;
            after_wr = last_wr_grp[a.res] + 9'd1;
            both     = (after_rd > after_wr) ? after_rd : after_wr;
            if (a.first) begin
                g = 0;
            end else if (a.wr || serialize_mdl) begin
                g = int'(both);
            end else if (a.rd) begin
                g = a.lay ? int'(both) : int'(after_wr);
            end else begin
                g = 0;
                flag_bad = 1'b1;
            end
            if (g > GROUP_N - 1) begin
                g = GROUP_N - 1;
                flag_ovf = 1'b1;
            end
            if (g > pass_floor) pass_floor = 8'(g);
            if (pass_log.size() < BUF_N) begin
                e.res = a.res;
                e.rd  = a.rd;
                e.wr  = a.wr;
                pass_log = {pass_log, e};
            end else begin
                flag_ovf = 1'b1;
            end
        end
        if (!a.pend) return;
        // Record the pass group for every buffered access
        foreach (pass_log[i]) begin
            if (pass_log[i].rd) last_rd_grp[pass_log[i].res] = {1'b0, pass_floor};
            if (pass_log[i].wr) last_wr_grp[pass_log[i].res] = {1'b0, pass_floor};
        end
        if (pass_floor > frame_top) frame_top = pass_floor;
        r.grp   = pass_floor;
        r.count = {1'b0, frame_top} + 9'd1;
        r.bad   = flag_bad;
        r.ovf   = flag_ovf;
        if (flag_bad) bad_results++;
        if (flag_ovf) ovf_results++;
        expected_passes = {expected_passes, r};
        pass_log.delete();
        pass_floor = '0;
        flag_bad   = 1'b0;
        flag_ovf   = 1'b0;
    endfunction

    // ---------------------------------------------------------------- transactions

    function automatic access_t one_access(input logic [7:0] res, input bit first,
                                           input bit rd, input bit wr, input bit lay,
                                           input bit pend);
        access_t a;
        a         = '0;
        a.present = 1'b1;
        a.res     = res;
        a.first   = first;
        a.rd      = rd;
        a.wr      = wr;
        a.lay     = lay;
        a.pend    = pend;
        return a;
    endfunction

    function automatic access_t random_access(input int pool, input bit pend);
        access_t a;
        int      pick;
        a         = '0;
        a.present = 1'b1;
        a.pend    = pend;
        a.res     = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                                : 8'($urandom_range(0, pool - 1));
        a.first   = ($urandom_range(0, 6) == 0);
        pick      = $urandom_range(0, 19);
        if (pick == 0) {a.rd, a.wr} = 2'b00;
        else {a.rd, a.wr} = 2'($urandom_range(1, 3));
        a.lay     = 1'($urandom_range(0, 1));
        return a;
    endfunction

    // Frame start with junk in the ignored fields
    function automatic access_t frame_item();
        access_t a;
        a.mode = 1'b1;
        a.res  = 8'($urandom_range(0, 255));
        {a.present, a.first, a.rd, a.wr, a.lay, a.pend} = 6'($urandom_range(0, 63));
        return a;
    endfunction

    function automatic access_t empty_item(input bit pend);
        access_t a;
        a      = '0;
        a.pend = pend;
        a.res  = 8'($urandom_range(0, 255));
        {a.first, a.rd, a.wr, a.lay} = 4'($urandom_range(0, 15));
        return a;
    endfunction

    // Offer one transaction; entered and left at a falling edge with valid still up
    task automatic send_item(input access_t a);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge aclk);
        end
        s_valid          <= 1'b1;
        s_mode           <= a.mode;
        s_resource       <= a.res;
        s_access_present <= a.present;
        s_first_access   <= a.first;
        s_reads          <= a.rd;
        s_writes         <= a.wr;
        s_layout_changes <= a.lay;
        s_pass_end       <= a.pend;
        do @(posedge aclk); while (!s_ready);
        assign_pass_group(a);
        items_sent++;
        @(negedge aclk);
    endtask

    // Drain the block, then write the serialize register
    task automatic set_serialize(input bit on);
        s_valid <= 1'b0;
        while (expected_passes.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= on;
        @(negedge aclk);
        cfg_wr_en     <= 1'b0;
        serialize_mdl  = on;
    endtask

    // ---------------------------------------------------------------- result side

    // Drop ready in random bursts, or for one long hold on request
    initial begin : result_receiver
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold_req) begin
                m_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge aclk);
                rx_hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 9) - 1) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Compare every result transaction against the oldest predicted pass
    always @(posedge aclk) begin : check_results
        pass_result_t due;
        if (aresetn && m_valid && m_ready) begin
            results_checked++;
            if (expected_passes.size() == 0) begin
                $error("unexpected pass result: m_group %0d m_group_count %0d",
                       m_group, m_group_count);
                fail_count++;
            end else begin
                due = expected_passes.pop_front();
                if (m_group !== due.grp) begin
                    $error("m_group: expected %0d, actual %0d", due.grp, m_group);
                    fail_count++;
                end
                if (m_group_count !== due.count) begin
                    $error("m_group_count: expected %0d, actual %0d", due.count,
                           m_group_count);
                    fail_count++;
                end
                if (m_bad_access !== due.bad) begin
                    $error("m_bad_access: expected %0b, actual %0b", due.bad, m_bad_access);
                    fail_count++;
                end
                if (m_overflow !== due.ovf) begin
                    $error("m_overflow: expected %0b, actual %0b", due.ovf, m_overflow);
                    fail_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- tests

    // Each grouping rule once, from empty tables
    task automatic test_directed_rules();
        send_item(one_access(8'd0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1));    // creation
        send_item(one_access(8'd0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1));    // write after write
        send_item(one_access(8'd0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1));    // read after write
        send_item(one_access(8'd0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1));    // read, layout change
        send_item(one_access(8'd0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1));    // neither read nor write
        send_item(empty_item(1'b1));                                  // pass with no accesses
        // Repeated resource in one pass, empty item in the middle
        send_item(one_access(8'd255, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0));
        send_item(one_access(8'd255, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
        send_item(empty_item(1'b0));
        send_item(one_access(8'd0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1));
        // Frame start drops the pass in progress
        send_item(one_access(8'd0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
        send_item(frame_item());
        send_item(one_access(8'd0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1));
        send_item(one_access(8'hAA, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
        send_item(one_access(8'h55, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1));
        send_item(one_access(8'hAA, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1));
    endtask

    // Every non-creating access waits like a write
    task automatic test_serialized_mode();
        set_serialize(1'b1);
        send_item(one_access(8'd3, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1));
        send_item(one_access(8'd3, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1));
        send_item(one_access(8'd3, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1));
        send_item(one_access(8'd3, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
        send_item(one_access(8'd3, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1));
        set_serialize(1'b0);
    endtask

    // Hold the result side while transactions keep coming, so the block fills up
    task automatic test_input_backpressure();
        rx_hold_req = 1'b1;
        for (int i = 0; i < 40; i++) send_item(random_access(8, 1'($urandom_range(0, 1))));
    endtask

    // Mostly well-formed passes over a small resource pool, some noise
    task automatic test_random_frames(input int n_items);
        int sent_here;
        int len;
        int pool;
        int k;
        sent_here = 0;
        pool      = $urandom_range(3, 24);
        while (sent_here < n_items) begin
            k = $urandom_range(0, 99);
            if (k < 3) begin
                send_item(frame_item());
                pool = $urandom_range(3, 24);
                sent_here++;
            end else if (k < 6) begin
                send_item(empty_item(1'($urandom_range(0, 1))));
                sent_here++;
            end else begin
                len = ($urandom_range(0, 29) == 0) ? $urandom_range(BUF_N - 2, BUF_N + 8)
                                                   : $urandom_range(1, 5);
                for (int i = 0; i < len; i++) begin
                    // Broken pass: frame start in the middle
                    if ($urandom_range(0, 199) == 0) begin
                        send_item(frame_item());
                        sent_here++;
                        break;
                    end
                    if ($urandom_range(0, 24) == 0) send_item(empty_item(i == len - 1));
                    else send_item(random_access(pool, i == len - 1));
                    sent_here++;
                end
            end
        end
    endtask

    // Chain of writes to one resource, pushing the group past the top
    task automatic test_group_saturation();
        send_item(frame_item());
        for (int i = 0; i < GROUP_N + 6; i++) begin
            if ($urandom_range(0, 3) == 0)
                send_item(one_access(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0,
                                     1'($urandom_range(0, 1)), 1'b0));
            send_item(one_access(8'd7, 1'b0, 1'b0, 1'b1, 1'($urandom_range(0, 1)), 1'b1));
        end
    endtask

    // Back-to-back traffic on both sides
    task automatic test_steady_stream();
        idle_on = 1'b0;
        test_random_frames(250);
    endtask

    initial begin
        aclk             = 1'b0;
        aresetn          = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_wr_data      = 1'b0;
        s_valid          = 1'b0;
        s_mode           = 1'b0;
        s_resource       = '0;
        s_access_present = 1'b0;
        s_first_access   = 1'b0;
        s_reads          = 1'b0;
        s_writes         = 1'b0;
        s_layout_changes = 1'b0;
        s_pass_end       = 1'b0;
        idle_on          = 1'b1;
        rx_hold_req      = 1'b0;
        serialize_mdl    = 1'b0;
        clear_frame_mdl();
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_rules();
        test_serialized_mode();
        test_input_backpressure();
        test_random_frames(350);
        set_serialize(1'b1);
        test_random_frames(250);
        set_serialize(1'b0);
        test_group_saturation();
        set_serialize(1'b1);
        test_random_frames(200);
        set_serialize(1'b0);
        test_steady_stream();

        // Drain and let the block settle
        s_valid <= 1'b0;
        while (expected_passes.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);

        $display("Covered %0d access transactions and %0d frame starts, %0d pass results",
                 items_sent, frames_seen, results_checked);
        $display("Passes with overflow: %0d, passes with a bad access: %0d",
                 ovf_results, bad_results);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/pdg_pkg.sv
rtl/pdg_dep_table.sv
rtl/pdg_pass_buf.sv
rtl/pass_dependency_grouper_top.sv
tb/pass_dependency_grouper_top_tb.sv
